// ----- rtl/core/olad_pkg.sv -----
// shared constants, codes and types of the ordered list block
`default_nettype none
package olad_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int POS_W = 4;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] element;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/olad_ram.sv -----
// generic single write port ram with registered read and read enable
`default_nettype none
module olad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- rtl/core/olad_ctrl.sv -----
// sequencer: append, search and shift for delete, dump walk over the entry ram
`default_nettype none
module olad_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [olad_pkg::OP_W-1:0]    i_operation,
    input  wire logic [olad_pkg::DATA_W-1:0]  i_value,
    output logic                              o_res_vld,
    output olad_pkg::t_result                 o_res,
    input  wire logic                         i_res_free
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DUMP  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    localparam int IW = olad_pkg::IDX_W;
    localparam int CW = olad_pkg::CNT_W;

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_occ, n_occ;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [olad_pkg::DATA_W-1:0]   r_val, n_val;
    logic [olad_pkg::ST_W-1:0]     r_status, n_status;

    logic                          wr_en;
    logic [IW-1:0]                 wr_addr;
    logic [olad_pkg::DATA_W-1:0]   wr_data;
    logic                          rd_en;
    logic [IW-1:0]                 rd_addr;
    logic [olad_pkg::DATA_W-1:0]   rd_data;

    logic [CW-1:0]                 occ_m1;
    logic [IW-1:0]                 idx_inc;
    logic                          is_tail;
    logic                          next_is_tail;
    logic                          accept;

    olad_ram #(
        .WIDTH (olad_pkg::DATA_W),
        .DEPTH (olad_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign occ_m1       = r_occ - 1'b1;
    assign idx_inc      = r_idx + 1'b1;
    assign is_tail      = (CW'(r_idx) == occ_m1);
    assign next_is_tail = (CW'(idx_inc) == occ_m1);
    assign o_in_ready   = (r_state == S_IDLE);
    assign accept       = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_occ    = r_occ;
        n_idx    = r_idx;
        n_val    = r_val;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = rd_data;
        rd_en    = 1'b0;
        rd_addr  = idx_inc;
        o_res_vld = 1'b0;
        o_res     = '{status: r_status, element: '0, position: '0, last: 1'b1};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val = i_value;
                    case (i_operation)
                        olad_pkg::OP_APPEND: begin
                            n_state = S_RESP;
                            if (r_occ == CW'(olad_pkg::DEPTH)) begin
                                n_status = olad_pkg::ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = r_occ[IW-1:0];
                                wr_data  = i_value;
                                n_occ    = r_occ + 1'b1;
                                n_status = olad_pkg::ST_OK;
                            end
                        end
                        olad_pkg::OP_DELETE: begin
                            if (r_occ == '0) begin
                                n_status = olad_pkg::ST_NOT_FOUND;
                                n_state  = S_RESP;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_SRCH;
                            end
                        end
                        olad_pkg::OP_DUMP: begin
                            if (r_occ == '0) begin
                                n_status = olad_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                // read of the next entry is issued every cycle, compare uses last read
                rd_en = 1'b1;
                if (rd_data == r_val) begin
                    if (is_tail) begin
                        n_occ    = r_occ - 1'b1;
                        n_status = olad_pkg::ST_OK;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (is_tail) begin
                    n_status = olad_pkg::ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_SHIFT: begin
                // rd_data holds the entry after r_idx
                wr_en = 1'b1;
                if (next_is_tail) begin
                    n_occ    = r_occ - 1'b1;
                    n_status = olad_pkg::ST_OK;
                    n_state  = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc + 1'b1;
                    n_idx   = idx_inc;
                end
            end
            S_DUMP: begin
                o_res_vld = 1'b1;
                o_res = '{status:   olad_pkg::ST_OK,
                          element:  rd_data,
                          position: olad_pkg::POS_W'(r_idx),
                          last:     is_tail};
                if (i_res_free) begin
                    if (is_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = idx_inc;
                    end
                end
            end
            S_RESP: begin
                o_res_vld = 1'b1;
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
    end

endmodule
`default_nettype wire

// ----- rtl/core/olad_out.sv -----
// output register stage holding one result transaction
`default_nettype none
module olad_out (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_res_vld,
    input  wire olad_pkg::t_result  i_res,
    output logic                    o_res_free,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output olad_pkg::t_result       o_res
);

    logic              r_vld, n_vld;
    olad_pkg::t_result r_res, n_res;

    assign o_res_free = !r_vld || i_out_ready;

    always_comb begin
        n_vld = r_vld;
        n_res = r_res;
        if (o_res_free) begin
            n_vld = i_res_vld;
            if (i_res_vld) begin
                n_res = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_res <= n_res;
    end

    assign o_out_valid = r_vld;
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ----- rtl/core/ordered_list_append_delete.sv -----
// top level of the ordered list block: append, delete first match, dump
//
// input channel (i_in_valid / o_in_ready) carries an operation and a value;
// output channel (o_out_valid / i_out_ready) carries status, element,
// position and last, one transaction per result.
// one input transaction is worked on at a time; o_in_ready is high only
// while the sequencer is idle, even if a result still waits in the output
// register.
// append and empty-list operations: the result passes from the response
// state to the output register; the next transaction is accepted once the sequencer is idle again.
// delete: entries are compared one by one up to the match (entry ram read
// port), then the entries behind it are moved down one by one to close the
// gap, then the result is handed over.
// dump: one result per cycle while the receiver takes them, the first entry
// read as the transaction is accepted; last is set on the tail entry.
// a stalled receiver holds the output register and the sequencer waits.
// reset empties the list at once; no clearing pass of the entry ram.
`default_nettype none
module ordered_list_append_delete (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic        [olad_pkg::OP_W-1:0]   i_operation,
    input  wire logic signed [olad_pkg::DATA_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic             [olad_pkg::ST_W-1:0]   o_status,
    output logic signed      [olad_pkg::DATA_W-1:0] o_element,
    output logic             [olad_pkg::POS_W-1:0]  o_position,
    output logic                                    o_last
);

    logic              res_vld;
    logic              res_free;
    olad_pkg::t_result res;
    olad_pkg::t_result out_res;

    olad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_res_vld   (res_vld),
        .o_res       (res),
        .i_res_free  (res_free)
    );

    olad_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_vld   (res_vld),
        .i_res       (res),
        .o_res_free  (res_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_status   = out_res.status;
    assign o_element  = out_res.element;
    assign o_position = out_res.position;
    assign o_last     = out_res.last;

endmodule
`default_nettype wire

// ----- verif/olad_list_checker.sv -----
// checker for the ordered list block: predicts every result and compares it on the output
module olad_list_checker
    import olad_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire logic        [OP_W-1:0]   i_operation,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire logic        [ST_W-1:0]   i_status,
    input  wire logic signed [DATA_W-1:0] i_element,
    input  wire logic        [POS_W-1:0]  i_position,
    input  wire logic                     i_last,
    output int                            o_errors,
    output int                            o_pending
);

    logic [DATA_W-1:0] list_mem [DEPTH];
    int                list_count;
    t_result           expected_results [$];
    t_result           got;
    t_result           want;
    int                err_count;

    task automatic predict_list_op(input logic [OP_W-1:0] op,
                                   input logic [DATA_W-1:0] val);
        t_result r;
        int      hit;
        int      k;
        r   = '{status: ST_OK, element: '0, position: '0, last: 1'b1};
        hit = -1;
        case (op)
            OP_APPEND: begin
                if (list_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_count] = val;
                    list_count++;
                end
                expected_results.push_back(r);
            end
            OP_DELETE: begin
                for (k = 0; k < list_count; k++) begin
                    if (hit < 0 && list_mem[k] == val) hit = k;
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (k = hit; k + 1 < list_count; k++) list_mem[k] = list_mem[k+1];
                    list_count--;
                end
                expected_results.push_back(r);
            end
            OP_DUMP: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                    expected_results.push_back(r);
                end else begin
                    for (k = 0; k < list_count; k++) begin
                        r.element  = list_mem[k];
                        r.position = POS_W'(k);
                        r.last     = (k == list_count - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_list_op(i_operation, i_value);
            if (i_out_valid && i_out_ready) begin
                got = '{status: i_status, element: i_element, position: i_position,
                        last: i_last};
                if (expected_results.size() == 0) begin
                    $display({"%0t: unexpected result: ",
                              "status %0d element %h position %0d last %0d"},
                             $time, got.status, got.element, got.position, got.last);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display({"%0t: result mismatch: expected ",
                                  "status %0d element %h position %0d last %0d"},
                                 $time, want.status, want.element, want.position,
                                 want.last);
                        $display({"%0t:                  actual ",
                                  "status %0d element %h position %0d last %0d"},
                                 $time, got.status, got.element, got.position,
                                 got.last);
                        err_count++;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= err_count;
    end

endmodule

// ----- verif/tb.sv -----
// testbench top for the ordered list block: stimulus, receiver stalls, watchdog and verdict
module tb;
    import olad_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 250;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic        [OP_W-1:0]   i_operation = OP_APPEND;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     i_out_ready = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic        [ST_W-1:0]   o_status;
    logic signed [DATA_W-1:0] o_element;
    logic        [POS_W-1:0]  o_position;
    logic                     o_last;

    int errors;
    int pending;
    int idle_cycles = 0;
    int results_seen = 0;
    int n_append = 0;
    int n_delete = 0;
    int n_dump = 0;
    int n_ignored = 0;
    int stall_mode = 0;
    int mode_cycles = 0;

    logic [DATA_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                                          32'h7fff_ffff, 32'h0000_0001, 32'h5a5a_5a5a,
                                          32'ha5a5_a5a5, 32'h0000_002a};

    always #4 i_clk = ~i_clk;

    ordered_list_append_delete dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_position  (o_position),
        .o_last      (o_last)
    );

    olad_list_checker list_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (o_status),
        .i_element   (o_element),
        .i_position  (o_position),
        .i_last      (o_last),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // receiver stall pattern, changes character whenever the mode_cycles counter wraps
    always @(posedge i_clk) begin
        mode_cycles++;
        if (mode_cycles == 50) begin
            mode_cycles = 0;
            stall_mode  = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ((mode_cycles % 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) results_seen++;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_txn(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (op)
            OP_APPEND: n_append++;
            OP_DELETE: n_delete++;
            OP_DUMP:   n_dump++;
            default:   n_ignored++;
        endcase
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_directed(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        send_txn(op, val);
        pause($urandom_range(0, 2));
    endtask

    initial begin
        int sent;
        int burst_len;
        int gap;
        int bias;
        int pick;
        int k;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases, extremes, head and middle delete, unused code
        send_directed(OP_DUMP, 32'h0);
        send_directed(OP_DELETE, 32'h0);
        send_directed(OP_APPEND, 32'h8000_0000);
        send_directed(OP_APPEND, 32'h7fff_ffff);
        send_directed(OP_APPEND, 32'h0000_0000);
        send_directed(OP_APPEND, 32'hffff_ffff);
        send_directed(OP_DUMP, 32'h0);
        send_directed(OP_DELETE, 32'h1234_5678);
        send_directed(OP_DELETE, 32'h0000_0000);
        send_directed(OP_DELETE, 32'h8000_0000);
        send_directed(OP_UNUSED, 32'hdead_beef);
        // fill with duplicates, overflow, full dump, repeated first-match delete
        for (k = 0; k < DEPTH - 2; k++) send_txn(OP_APPEND, 32'h0000_0007);
        send_directed(OP_APPEND, 32'h0bad_0bad);
        send_directed(OP_DUMP, 32'h0);
        send_directed(OP_DELETE, 32'h0000_0007);
        send_directed(OP_DELETE, 32'h0000_0007);
        send_directed(OP_DUMP, 32'h0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 16);
            gap       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            bias      = $urandom_range(0, 2);
            for (k = 0; k < burst_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < ((bias == 0) ? 65 : (bias == 1) ? 25 : 45)) op = OP_APPEND;
                else if (pick < 80) op = OP_DELETE;
                else if (pick < 97) op = OP_DUMP;
                else op = OP_UNUSED;
                pick = $urandom_range(0, 9);
                val  = (pick < 8) ? value_pool[pick] : $urandom();
                send_txn(op, val);
                if (op != OP_UNUSED) sent++;
            end
            pause(gap);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("tb: sent %0d appends, %0d deletes, %0d dumps, %0d unused codes",
                 n_append, n_delete, n_dump, n_ignored);
        $display("tb: %0d results received, %0d mismatches", results_seen, errors);
        if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
        if (errors == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/olad_pkg.sv
rtl/core/olad_ram.sv
rtl/core/olad_ctrl.sv
rtl/core/olad_out.sv
rtl/core/ordered_list_append_delete.sv
verif/olad_list_checker.sv
verif/tb.sv
